@@ src/bpe_pretokenizer_splitter_macros.svh @@
// Assertion helpers for the pre-token splitter checkers.
`ifndef BPE_PRETOKENIZER_SPLITTER_MACROS_SVH
`define BPE_PRETOKENIZER_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Beat types and character constants for the pre-token splitter.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);
    localparam int IDX_BITS = $clog2(MAX_RESULTS);

    localparam logic [20:0] CH_TAB   = 21'h09;
    localparam logic [20:0] CH_LF    = 21'h0A;
    localparam logic [20:0] CH_VT    = 21'h0B;
    localparam logic [20:0] CH_FF    = 21'h0C;
    localparam logic [20:0] CH_CR    = 21'h0D;
    localparam logic [20:0] CH_SPACE = 21'h20;
    localparam logic [20:0] CH_APOS  = 21'h27;

    typedef struct packed {
        logic [20:0] code_point;
        logic        end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] piece_start;
        logic [15:0] piece_end;
        logic        final_piece;
        logic        position_overflow;
    } out_beat_t;

    typedef out_beat_t [MAX_RESULTS-1:0] res_list_t;

    typedef struct packed {
        res_list_t             res;
        logic [CNT_BITS-1:0]   cnt;
    } res_bundle_t;

endpackage

@@ src/bpe_pretokenizer_splitter.sv @@
// ----------------------------------------------------------------------------
// bpe_pretokenizer_splitter
// Streaming pre-token splitter: code points in, piece boundaries out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one code point per beat, end_of_text on the last of a text.
//   m_ channel: one piece per beat (start, end exclusive, final, overflow).
//   Each accepted code point yields zero to four pieces. They are computed
//   in the accepting cycle and held in a result register, then shown one
//   per cycle while m_ready is high; the first appears in the cycle after
//   the code point is accepted. Boundaries that need lookahead appear on
//   the beat that settles them. Throughput: one code point per cycle while
//   each yields at most one piece and m_ready is high; one yielding more
//   pieces holds s_ready low until the single result port has drained the
//   result register to its last piece. s_ready stays high while the last
//   pending piece is taken; a stalled receiver blocks input while one waits.
//   Reset: position 0, no open piece, nothing pending; no clearing pass.
//   After end_of_text the next beat starts a new text at position 0.
// ----------------------------------------------------------------------------
module bpe_pretokenizer_splitter import bps_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    res_bundle_t          bundle;
    res_list_t            res_reg;
    logic [CNT_BITS-1:0]  left_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic                 s_fire;
    logic                 m_fire;

    assign m_valid = left_reg != '0;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (left_reg == '0) || (left_reg == CNT_BITS'(1) && m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_data  = res_reg[idx_reg];

    bps_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_fire),
        .beat    (s_data),
        .bundle  (bundle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else if (s_fire) begin
            left_reg <= bundle.cnt;
            idx_reg  <= '0;
        end else if (m_fire) begin
            left_reg <= left_reg - CNT_BITS'(1);
            idx_reg  <= idx_reg + IDX_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) res_reg <= bundle.res;
    end

endmodule

@@ src/bps_lexer.sv @@
// ----------------------------------------------------------------------------
// bps_lexer
// Lexer state and per-beat split decision; yields up to four pieces per beat.
// ----------------------------------------------------------------------------
module bps_lexer import bps_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  in_beat_t    beat,
    output res_bundle_t bundle
);

    localparam int P = POSITION_BITS;

    typedef enum logic [2:0] {
        M_IDLE, M_PEND1, M_PEND2, M_LET, M_SYM, M_SYMNL, M_SPACE
    } mode_t;

    typedef struct packed {
        mode_t         mode;
        logic [P-1:0]  ops;
        logic [1:0]    fill;
        logic [20:0]   win0;
        logic [20:0]   win1;
        logic [P-1:0]  rlnl;
        logic          rhnl;
        logic          wrap;
        res_list_t     res;
        logic [CNT_BITS-1:0] cnt;
    } work_t;

    mode_t        mode_reg, mode_next;
    logic [P-1:0] ops_reg, ops_next;
    logic [1:0]   fill_reg, fill_next;
    logic [20:0]  win0_reg, win0_next;
    logic [20:0]  win1_reg, win1_next;
    logic [P-1:0] rlnl_reg, rlnl_next;
    logic         rhnl_reg, rhnl_next;
    logic [P-1:0] pos_reg, pos_next;
    logic         wrapped_reg, wrapped_next;
    work_t        w_final;

    function automatic logic cp_alpha(logic [20:0] c);
        return (c >= 21'd128) || (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A);
    endfunction

    function automatic logic cp_num(logic [20:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic is_nl(logic [20:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic cp_blank(logic [20:0] c);
        return c == CH_SPACE || c == CH_TAB || is_nl(c) || c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic is_sym(logic [20:0] c);
        return !cp_blank(c) && !cp_alpha(c) && !cp_num(c);
    endfunction

    function automatic logic [20:0] fold(logic [20:0] c);
        return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
    endfunction

    function automatic logic [P-1:0] inc(logic [P-1:0] p);
        return p + P'(1);
    endfunction

    function automatic work_t emit(work_t w, logic [P-1:0] a, logic [P-1:0] b);
        work_t r;
        r = w;
        if (w.cnt < CNT_BITS'(MAX_RESULTS)) begin
            r.res[w.cnt[IDX_BITS-1:0]].piece_start       = 16'(a);
            r.res[w.cnt[IDX_BITS-1:0]].piece_end         = 16'(b);
            r.res[w.cnt[IDX_BITS-1:0]].final_piece       = 1'b0;
            r.res[w.cnt[IDX_BITS-1:0]].position_overflow = w.wrap;
            r.cnt = w.cnt + CNT_BITS'(1);
        end
        return r;
    endfunction

    function automatic work_t start_piece(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t r;
        r = w;
        r.fill = 2'd0;
        if (cp_alpha(c)) begin
            r.mode = M_LET;
            r.ops  = p;
        end else if (cp_num(c)) begin
            r.mode = M_IDLE;
            r = emit(r, p, inc(p));
        end else if (is_nl(c)) begin
            r.mode = M_SPACE;
            r.ops  = p;
            r.rhnl = 1'b1;
            r.rlnl = p;
            r.win0 = c;
        end else begin
            r.win0 = c;
            r.fill = 2'd1;
            r.mode = M_PEND1;
            r.ops  = p;
        end
        return r;
    endfunction

    // Whitespace run ends; its last char may join the following text.
    function automatic work_t resolve_space(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t        r;
        logic [P-1:0] q;
        logic [P-1:0] s;
        r = w;
        q = w.ops;
        s = p - P'(1);
        r.mode = M_IDLE;
        r.fill = 2'd0;
        if (w.rhnl) begin
            r = emit(r, q, inc(w.rlnl));
            q = inc(w.rlnl);
        end
        r.rhnl = 1'b0;
        if (w.fill == 2'd0) begin
            r = start_piece(r, c, p);
        end else begin
            if (w.fill >= 2'd2) r = emit(r, q, s);
            if (cp_alpha(c)) begin
                r.mode = M_LET;
                r.ops  = s;
            end else if (w.win0 == CH_SPACE && is_sym(c)) begin
                r.mode = M_SYM;
                r.ops  = s;
            end else begin
                r = emit(r, s, p);
                r = start_piece(r, c, p);
            end
        end
        return r;
    endfunction

    function automatic work_t feed_let(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t r;
        r = w;
        if (!cp_alpha(c)) begin
            r = emit(r, w.ops, p);
            r.mode = M_IDLE;
            r = start_piece(r, c, p);
        end
        return r;
    endfunction

    function automatic work_t feed_sym(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t r;
        r = w;
        if (is_nl(c)) begin
            r.mode = M_SYMNL;
        end else if (!is_sym(c)) begin
            r = emit(r, w.ops, p);
            r.mode = M_IDLE;
            r = start_piece(r, c, p);
        end
        return r;
    endfunction

    function automatic work_t feed_space(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t r;
        r = w;
        if (cp_blank(c)) begin
            r.win0 = c;
            if (is_nl(c)) begin
                r.rhnl = 1'b1;
                r.rlnl = p;
                r.fill = 2'd0;
            end else if (w.fill < 2'd2) begin
                r.fill = w.fill + 2'd1;
            end
        end else begin
            r = resolve_space(r, c, p);
        end
        return r;
    endfunction

    function automatic work_t feed(work_t w, logic [20:0] c, logic [P-1:0] p);
        work_t       r;
        logic [20:0] f;
        logic [20:0] a;
        r = w;
        f = fold(c);
        a = fold(w.win1);
        unique case (w.mode)
            M_PEND1: begin
                if (w.win0 == CH_APOS && (f == 21'h73 || f == 21'h74 || f == 21'h6D
                        || f == 21'h64)) begin
                    r = emit(r, w.ops, inc(p));
                    r.mode = M_IDLE;
                    r.fill = 2'd0;
                end else if (w.win0 == CH_APOS && (f == 21'h72 || f == 21'h76
                        || f == 21'h6C)) begin
                    r.win1 = c;
                    r.fill = 2'd2;
                    r.mode = M_PEND2;
                end else begin
                    r.fill = 2'd0;
                    if (cp_alpha(c)) begin
                        r.mode = M_LET;
                    end else if (w.win0 == CH_SPACE && is_sym(c)) begin
                        r.mode = M_SYM;
                    end else if (is_sym(w.win0)) begin
                        r.mode = M_SYM;
                        r = feed_sym(r, c, p);
                    end else begin
                        r.mode = M_SPACE;
                        r.rhnl = 1'b0;
                        r.fill = 2'd1;
                        r = feed_space(r, c, p);
                    end
                end
            end
            M_PEND2: begin
                r.fill = 2'd0;
                if ((a == 21'h72 && f == 21'h65) || (a == 21'h76 && f == 21'h65)
                        || (a == 21'h6C && f == 21'h6C)) begin
                    r = emit(r, w.ops, inc(p));
                    r.mode = M_IDLE;
                end else begin
                    r.mode = M_LET;
                    r = feed_let(r, c, p);
                end
            end
            M_LET:   r = feed_let(r, c, p);
            M_SYM:   r = feed_sym(r, c, p);
            M_SYMNL: begin
                if (!is_nl(c)) begin
                    r = emit(r, w.ops, p);
                    r.mode = M_IDLE;
                    r = start_piece(r, c, p);
                end
            end
            M_SPACE: r = feed_space(r, c, p);
            default: r = start_piece(r, c, p);
        endcase
        return r;
    endfunction

    // End of text: close whatever is open at position n.
    function automatic work_t flush(work_t w, logic [P-1:0] n);
        work_t r;
        r = w;
        case (w.mode)
            M_PEND1, M_PEND2, M_LET, M_SYM, M_SYMNL: r = emit(r, w.ops, n);
            M_SPACE: begin
                if (w.rhnl) begin
                    r = emit(r, w.ops, inc(w.rlnl));
                    if (w.fill != 2'd0) r = emit(r, inc(w.rlnl), n);
                end else begin
                    r = emit(r, w.ops, n);
                end
            end
            default: r = w;
        endcase
        if (r.cnt != '0) r.res[IDX_BITS'(r.cnt - CNT_BITS'(1))].final_piece = 1'b1;
        return r;
    endfunction

    always_comb begin
        work_t w0;
        w0.mode = mode_reg;
        w0.ops  = ops_reg;
        w0.fill = fill_reg;
        w0.win0 = win0_reg;
        w0.win1 = win1_reg;
        w0.rlnl = rlnl_reg;
        w0.rhnl = rhnl_reg;
        w0.wrap = wrapped_reg || (inc(pos_reg) == '0);
        w0.res  = '0;
        w0.cnt  = '0;
        w_final = feed(w0, beat.code_point, pos_reg);
        if (beat.end_of_text) w_final = flush(w_final, inc(pos_reg));

        mode_next    = w_final.mode;
        ops_next     = w_final.ops;
        fill_next    = w_final.fill;
        win0_next    = w_final.win0;
        win1_next    = w_final.win1;
        rlnl_next    = w_final.rlnl;
        rhnl_next    = w_final.rhnl;
        pos_next     = inc(pos_reg);
        wrapped_next = w0.wrap;
        if (beat.end_of_text) begin
            mode_next    = M_IDLE;
            ops_next     = '0;
            fill_next    = 2'd0;
            rlnl_next    = '0;
            rhnl_next    = 1'b0;
            pos_next     = '0;
            wrapped_next = 1'b0;
        end
    end

    assign bundle.res = w_final.res;
    assign bundle.cnt = w_final.cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            ops_reg     <= '0;
            fill_reg    <= 2'd0;
            rlnl_reg    <= '0;
            rhnl_reg    <= 1'b0;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            ops_reg     <= ops_next;
            fill_reg    <= fill_next;
            rlnl_reg    <= rlnl_next;
            rhnl_reg    <= rhnl_next;
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Lookahead window carries no reset; it is always written before use.
    always_ff @(posedge aclk) begin
        if (accept) begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
        end
    end

endmodule

@@ src/bps_checker.sv @@
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks for the pre-token splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bpe_pretokenizer_splitter_macros.svh"

module bps_checker import bps_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `BPS_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // Nothing pending means the input side must be open.
    `BPS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input blocked with no result pending")

    // End of text always closes at least one piece.
    `BPS_ASSERT_NEXT(a_eot_result, aclk, aresetn, s_valid && s_ready && s_data.end_of_text, m_valid, "end of text gave no piece")

endmodule

bind bpe_pretokenizer_splitter bps_checker u_bps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pre-token splitter against a behavioral piece-boundary model:
// a directed table of texts, then random well-formed texts with random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import bps_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE, LX_PEND1, LX_PEND2, LX_LETTERS, LX_SYMBOLS, LX_SYM_NL, LX_SPACE
    } lex_mode_e;

    typedef struct {
        logic [20:0] cp;
        logic        eot;
        bit          has_exp;
        out_beat_t   exp;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    bpe_pretokenizer_splitter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // splitter state mirror
    logic [15:0] pos_next;
    logic [15:0] piece_open;
    lex_mode_e   lx_mode;
    logic [20:0] held_cp [2];
    int unsigned held_cnt;
    logic [15:0] last_nl;
    bit          run_nl;
    bit          wrapped;

    out_beat_t   piece_q [$];
    out_beat_t   step_pieces [$];
    int          mismatches;
    int          pieces_seen;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          recv_hold;
    longint      cycles;

    function automatic bit tb_alpha(logic [20:0] c);
        return c >= 128 || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit tb_num(logic [20:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit is_nl(logic [20:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction
    function automatic bit is_ws(logic [20:0] c);
        return c == CH_SPACE || c == CH_TAB || is_nl(c) || c == CH_VT || c == CH_FF;
    endfunction
    function automatic bit is_sym(logic [20:0] c);
        return !is_ws(c) && !tb_alpha(c) && !tb_num(c);
    endfunction
    function automatic logic [20:0] lower(logic [20:0] c);
        return (c >= "A" && c <= "Z") ? c + 21'd32 : c;
    endfunction

    task automatic add_piece(logic [15:0] a, logic [15:0] b);
        out_beat_t r;
        if (step_pieces.size() >= MAX_RESULTS) return;
        r.piece_start = a;
        r.piece_end = b;
        r.final_piece = 1'b0;
        r.position_overflow = wrapped;
        step_pieces = {step_pieces, r};
    endtask

    task automatic begin_piece(logic [20:0] c, logic [15:0] p);
        held_cnt = 0;
        if (tb_alpha(c)) begin
            lx_mode = LX_LETTERS; piece_open = p;
        end else if (tb_num(c)) begin
            lx_mode = LX_IDLE; add_piece(p, p + 16'd1);
        end else if (is_nl(c)) begin
            lx_mode = LX_SPACE; piece_open = p;
            run_nl = 1; last_nl = p; held_cp[0] = c;
        end else begin
            held_cp[0] = c; held_cnt = 1;
            lx_mode = LX_PEND1; piece_open = p;
        end
    endtask

    task automatic close_space(logic [20:0] c, logic [15:0] p);
        logic [15:0] q;
        logic [15:0] s;
        int unsigned r;
        q = piece_open;
        r = held_cnt;
        s = p - 16'd1;
        lx_mode = LX_IDLE;
        held_cnt = 0;
        if (run_nl) begin
            add_piece(q, last_nl + 16'd1);
            q = last_nl + 16'd1;
        end
        run_nl = 0;
        if (r == 0) begin
            begin_piece(c, p);
            return;
        end
        if (r >= 2) add_piece(q, s);
        if (tb_alpha(c)) begin
            lx_mode = LX_LETTERS; piece_open = s;
        end else if (held_cp[0] == CH_SPACE && is_sym(c)) begin
            lx_mode = LX_SYMBOLS; piece_open = s;
        end else begin
            add_piece(s, p);
            begin_piece(c, p);
        end
    endtask

    task automatic lex_char(logic [20:0] c, logic [15:0] p);
        logic [20:0] c0;
        logic [20:0] f;
        bit again;
        again = 1;
        while (again) begin
            again = 0;
            case (lx_mode)
                LX_PEND1: begin
                    c0 = held_cp[0];
                    f = lower(c);
                    if (c0 == CH_APOS && (f == "s" || f == "t" || f == "m" || f == "d")) begin
                        add_piece(piece_open, p + 16'd1); lx_mode = LX_IDLE; held_cnt = 0;
                    end else if (c0 == CH_APOS && (f == "r" || f == "v" || f == "l")) begin
                        held_cp[1] = c; held_cnt = 2; lx_mode = LX_PEND2;
                    end else begin
                        held_cnt = 0;
                        if (tb_alpha(c)) lx_mode = LX_LETTERS;
                        else if (c0 == CH_SPACE && is_sym(c)) lx_mode = LX_SYMBOLS;
                        else if (is_sym(c0)) begin
                            lx_mode = LX_SYMBOLS; again = 1;
                        end else begin
                            lx_mode = LX_SPACE; run_nl = 0; held_cnt = 1; again = 1;
                        end
                    end
                end
                LX_PEND2: begin
                    f = lower(held_cp[1]);
                    c0 = lower(c);
                    held_cnt = 0;
                    if ((f == "r" && c0 == "e") || (f == "v" && c0 == "e") ||
                        (f == "l" && c0 == "l")) begin
                        add_piece(piece_open, p + 16'd1); lx_mode = LX_IDLE;
                    end else begin
                        lx_mode = LX_LETTERS; again = 1;
                    end
                end
                LX_LETTERS: begin
                    if (!tb_alpha(c)) begin
                        add_piece(piece_open, p); lx_mode = LX_IDLE; begin_piece(c, p);
                    end
                end
                LX_SYMBOLS: begin
                    if (is_nl(c)) lx_mode = LX_SYM_NL;
                    else if (!is_sym(c)) begin
                        add_piece(piece_open, p); lx_mode = LX_IDLE; begin_piece(c, p);
                    end
                end
                LX_SYM_NL: begin
                    if (!is_nl(c)) begin
                        add_piece(piece_open, p); lx_mode = LX_IDLE; begin_piece(c, p);
                    end
                end
                LX_SPACE: begin
                    if (is_ws(c)) begin
                        held_cp[0] = c;
                        if (is_nl(c)) begin
                            run_nl = 1; last_nl = p; held_cnt = 0;
                        end else if (held_cnt < 2) held_cnt++;
                    end else close_space(c, p);
                end
                default: begin_piece(c, p);
            endcase
        end
    endtask

    task automatic clear_text();
        pos_next = 0; piece_open = 0; lx_mode = LX_IDLE;
        held_cnt = 0; last_nl = 0; run_nl = 0; wrapped = 0;
    endtask

    // predicts the pieces produced by one code point beat
    task automatic predict_pieces(in_beat_t b);
        logic [15:0] p;
        step_pieces.delete();
        p = pos_next;
        pos_next = p + 16'd1;
        if (pos_next == 0) wrapped = 1;
        lex_char(b.code_point, p);
        if (b.end_of_text) begin
            case (lx_mode)
                LX_PEND1, LX_PEND2, LX_LETTERS, LX_SYMBOLS, LX_SYM_NL:
                    add_piece(piece_open, pos_next);
                LX_SPACE: begin
                    if (run_nl) begin
                        add_piece(piece_open, last_nl + 16'd1);
                        if (held_cnt > 0) add_piece(last_nl + 16'd1, pos_next);
                    end else add_piece(piece_open, pos_next);
                end
                default: ;
            endcase
            if (step_pieces.size() > 0)
                step_pieces[step_pieces.size()-1].final_piece = 1'b1;
            clear_text();
        end
        foreach (step_pieces[i]) piece_q = {piece_q, step_pieces[i]};
    endtask

    task automatic report_mismatch(string what, out_beat_t e, out_beat_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d..%0d f%0b o%0b, got %0d..%0d f%0b o%0b", what,
                     e.piece_start, e.piece_end, e.final_piece, e.position_overflow,
                     a.piece_start, a.piece_end, a.final_piece, a.position_overflow);
    endtask

    // valid stays up after acceptance; the next beat or an idle cycle replaces it
    task automatic send_beat(logic [20:0] cp, logic eot);
        in_beat_t b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        b.code_point = cp;
        b.end_of_text = eot;
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pieces(b);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (piece_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [20:0] rand_cp(int unsigned kind);
        case (kind)
            0: return 21'("a" + $urandom_range(25));
            1: return 21'("A" + $urandom_range(25));
            2: return 21'("0" + $urandom_range(9));
            3: return CH_SPACE;
            4: return CH_LF;
            5: return CH_CR;
            6: begin
                case ($urandom_range(2))
                    0: return CH_TAB;
                    1: return CH_VT;
                    default: return CH_FF;
                endcase
            end
            7: return CH_APOS;
            8: return 21'("!" + $urandom_range(14));
            9: return 21'($urandom_range(21'h1FFFFF, 128));
            default: return 21'($urandom_range(127));
        endcase
    endfunction

    task automatic send_random_text(int unsigned len);
        logic [20:0] c;
        string contr;
        int unsigned k;
        k = 0;
        while (k < len) begin
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(6))
                    0: contr = "'s"; 1: contr = "'T"; 2: contr = "'re";
                    3: contr = "'Ve"; 4: contr = "'m"; 5: contr = "'lL";
                    default: contr = "'d";
                endcase
                for (int i = 0; i < contr.len() && k < len; i++) begin
                    k++;
                    send_beat(21'(contr[i]), k == len);
                end
            end else begin
                c = rand_cp($urandom_range(10));
                k++;
                send_beat(c, k == len);
            end
        end
    endtask

    // result channel: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            pieces_seen++;
            if (piece_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected piece %0d..%0d", m_data.piece_start, m_data.piece_end);
            end else begin
                if (m_data !== piece_q[0]) report_mismatch("piece", piece_q[0], m_data);
                void'(piece_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 60000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    stim_row_t dir_rows [$];

    task automatic add_row(logic [20:0] cp, logic eot);
        stim_row_t r;
        r.cp = cp; r.eot = eot; r.has_exp = 0; r.exp = '0;
        dir_rows = {dir_rows, r};
    endtask

    initial begin
        stim_row_t r;
        out_beat_t got_exp;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        mismatches = 0;
        pieces_seen = 0;
        cycles = 0;
        recv_hold = 0;
        send_idle_pct = 11;
        recv_idle_pct = 66;
        clear_text();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single digit text, largest code point, contractions, ws runs
        r = '{cp: "7", eot: 1'b1, has_exp: 1, exp: '{16'd0, 16'd1, 1'b1, 1'b0}};
        dir_rows = {dir_rows, r};
        r = '{cp: 21'h1FFFFF, eot: 1'b1, has_exp: 1, exp: '{16'd0, 16'd1, 1'b1, 1'b0}};
        dir_rows = {dir_rows, r};
        add_row(CH_APOS, 0); add_row("S", 0); add_row(CH_APOS, 0); add_row("r", 0);
        add_row("E", 0); add_row(CH_APOS, 0); add_row("L", 0); add_row("x", 0);
        add_row(CH_SPACE, 0); add_row(CH_SPACE, 0); add_row(CH_TAB, 0); add_row("!", 0);
        add_row(CH_CR, 0); add_row(CH_VT, 0); add_row(CH_LF, 0); add_row(CH_FF, 0);
        add_row(CH_SPACE, 0); add_row(21'h10FFFF, 0); add_row(CH_SPACE, 0);
        add_row(CH_LF, 0); add_row(CH_SPACE, 1);
        add_row(CH_APOS, 1);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp) begin
                send_beat(dir_rows[i].cp, dir_rows[i].eot);
                got_exp = piece_q[piece_q.size()-1];
                if (got_exp !== dir_rows[i].exp) report_mismatch("table", dir_rows[i].exp, got_exp);
            end else send_beat(dir_rows[i].cp, dir_rows[i].eot);
        end

        // long receiver hold-off while the sender keeps going
        fork
            begin
                recv_hold <= 1'b1;
                repeat (60) @(posedge aclk);
                recv_hold <= 1'b0;
            end
            send_random_text(20);
        join
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 66 : 0;
            recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 11 : 0;
            for (int t = 0; t < 16; t++) send_random_text($urandom_range(14, 1));
            wait_drained();
        end

        send_random_text(30);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && piece_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
